FILE: sv/hwtc_pkg.sv
// ----------------------------------------------------------------------------
// hwtc_pkg
// Shared types and constants for the hysteresis wheel tick counter.
// ----------------------------------------------------------------------------
package hwtc_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS    = 10;
  localparam int CHANNEL_BITS   = 1;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 10;

  // Threshold reset values
  localparam logic [SAMPLE_BITS-1:0] LOW_THRESHOLD_RESET  = SAMPLE_BITS'(400);
  localparam logic [SAMPLE_BITS-1:0] HIGH_THRESHOLD_RESET = SAMPLE_BITS'(450);

  // Reset values of the per-channel reading trackers
  localparam logic [SAMPLE_BITS-1:0] MIN_READING_RESET = '1;
  localparam logic [SAMPLE_BITS-1:0] MAX_READING_RESET = '0;

  // Item operations
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_PRESET = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOW_THRESHOLD  = 1'b0,
    CFG_HIGH_THRESHOLD = 1'b1
  } cfg_index_t;

endpackage

FILE: sv/hwtc_sample_if.sv
// ----------------------------------------------------------------------------
// hwtc_sample_if
// Input item channel: a sample or a count preset for one channel.
// ----------------------------------------------------------------------------
interface hwtc_sample_if #(
  parameter int COUNT_BITS = 16
);

  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [hwtc_pkg::CHANNEL_BITS-1:0] channel;
  logic [hwtc_pkg::SAMPLE_BITS-1:0]  sample;
  logic [COUNT_BITS-1:0]             preset_value;

  modport source (
    output valid, operation, channel, sample, preset_value,
    input  ready
  );

  modport sink (
    input  valid, operation, channel, sample, preset_value,
    output ready
  );

endinterface

FILE: sv/hwtc_result_if.sv
// ----------------------------------------------------------------------------
// hwtc_result_if
// Result item channel: the addressed channel's state after an item.
// ----------------------------------------------------------------------------
interface hwtc_result_if #(
  parameter int COUNT_BITS = 16
);

  logic                             valid;
  logic                             ready;
  logic [COUNT_BITS-1:0]            tick_count;
  logic                             level;
  logic [hwtc_pkg::SAMPLE_BITS-1:0] lowest_seen;
  logic [hwtc_pkg::SAMPLE_BITS-1:0] highest_seen;

  modport source (
    output valid, tick_count, level, lowest_seen, highest_seen,
    input  ready
  );

  modport sink (
    input  valid, tick_count, level, lowest_seen, highest_seen,
    output ready
  );

endinterface

FILE: sv/hwtc_cfg_if.sv
// ----------------------------------------------------------------------------
// hwtc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hwtc_cfg_if;

  logic                               valid;
  logic                               ready;
  logic [hwtc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [hwtc_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );

endinterface

FILE: sv/hysteresis_wheel_tick_counter.sv
// ----------------------------------------------------------------------------
// hysteresis_wheel_tick_counter
// Per-channel hysteresis level detector and tick counter for wheel encoders.
// ----------------------------------------------------------------------------
// Each input item either carries an analog reading for one channel or presets
// that channel's tick count, and yields exactly one result item with the
// channel's count, level flag and lowest/highest reading after the item. The
// block takes one item per clock while the result register is free or being
// taken, and returns its result through the input register, then the result
// register. The read-modify-write of the per-channel state completes
// combinationally between those two registers, so items on the same channel
// may follow each other back to back. Threshold writes take effect on the
// next cycle and are always accepted.
module hysteresis_wheel_tick_counter #(
  parameter int CHANNELS   = 2,
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  hwtc_sample_if.sink   samples,
  hwtc_result_if.source results,
  hwtc_cfg_if.sink      cfg
);

  import hwtc_pkg::*;

  localparam int CH_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Threshold registers
  logic [SAMPLE_BITS-1:0] low_threshold;
  logic [SAMPLE_BITS-1:0] high_threshold;

  // Input register
  logic                    s1_valid;
  op_t                     s1_operation;
  logic [CHANNEL_BITS-1:0] s1_channel;
  logic [SAMPLE_BITS-1:0]  s1_sample;
  logic [COUNT_BITS-1:0]   s1_preset;

  // Result register
  logic                   res_valid;
  logic [COUNT_BITS-1:0]  res_count;
  logic                   res_level;
  logic [SAMPLE_BITS-1:0] res_lowest;
  logic [SAMPLE_BITS-1:0] res_highest;

  // Per-channel state
  logic [COUNT_BITS-1:0]  tick_counts      [CHANNELS];
  logic                   level_flags      [CHANNELS];
  logic [SAMPLE_BITS-1:0] minimum_readings [CHANNELS];
  logic [SAMPLE_BITS-1:0] maximum_readings [CHANNELS];

  // Update path
  logic                   advance;
  logic [CH_BITS-1:0]     ch_idx;
  logic [COUNT_BITS-1:0]  count_rd;
  logic                   level_rd;
  logic [SAMPLE_BITS-1:0] min_rd;
  logic [SAMPLE_BITS-1:0] max_rd;
  logic                   fall;
  logic                   level_mid;
  logic                   rise;
  logic [COUNT_BITS-1:0]  count_next;
  logic                   level_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic [SAMPLE_BITS-1:0] max_next;

  // Handshakes
  assign advance       = s1_valid && (!res_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign cfg.ready     = 1'b1;

  // Write threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= LOW_THRESHOLD_RESET;
      high_threshold <= HIGH_THRESHOLD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_index_t'(cfg.index))
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg.data;
        CFG_HIGH_THRESHOLD: high_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_operation <= op_t'(samples.operation);
      s1_channel   <= samples.channel;
      s1_sample    <= samples.sample;
      s1_preset    <= samples.preset_value;
    end
  end

  // Fold the channel number into the implemented channels
  assign ch_idx = (CHANNELS > 1) ? CH_BITS'(s1_channel) : '0;

  // Read the addressed channel
  assign count_rd = tick_counts[ch_idx];
  assign level_rd = level_flags[ch_idx];
  assign min_rd   = minimum_readings[ch_idx];
  assign max_rd   = maximum_readings[ch_idx];

  // Apply the low test first, then the high test on the updated flag
  always_comb begin
    fall       = (s1_sample < low_threshold) && level_rd;
    level_mid  = level_rd && !fall;
    rise       = (s1_sample > high_threshold) && !level_mid;
    count_next = count_rd;
    level_next = level_rd;
    min_next   = min_rd;
    max_next   = max_rd;
    case (s1_operation)
      OP_PRESET: begin
        count_next = s1_preset;
      end
      OP_SAMPLE: begin
        count_next = count_rd + COUNT_BITS'(fall) + COUNT_BITS'(rise);
        level_next = level_mid || rise;
        min_next   = (s1_sample < min_rd) ? s1_sample : min_rd;
        max_next   = (s1_sample > max_rd) ? s1_sample : max_rd;
      end
      default: ;
    endcase
  end

  // Write back the channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        tick_counts[c]      <= '0;
        level_flags[c]      <= 1'b0;
        minimum_readings[c] <= MIN_READING_RESET;
        maximum_readings[c] <= MAX_READING_RESET;
      end
    end else if (advance) begin
      tick_counts[ch_idx]      <= count_next;
      level_flags[ch_idx]      <= level_next;
      minimum_readings[ch_idx] <= min_next;
      maximum_readings[ch_idx] <= max_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_count   <= count_next;
      res_level   <= level_next;
      res_lowest  <= min_next;
      res_highest <= max_next;
    end
  end

  assign results.valid        = res_valid;
  assign results.tick_count   = res_count;
  assign results.level        = res_level;
  assign results.lowest_seen  = res_lowest;
  assign results.highest_seen = res_highest;

`ifndef SYNTHESIS
  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result pending after reset");

  // A stalled input item stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_sample) && $stable(s1_preset))
    else $error("input item lost while stalled");

  // A preset shows up unchanged in the result
  a_preset_count: assert property (@(posedge clk) disable iff (rst)
    advance && s1_operation == OP_PRESET |=> res_count == $past(s1_preset))
    else $error("preset count not reported");

  // After a sample the channel's range is never inverted
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    advance && s1_operation == OP_SAMPLE |=> res_lowest <= res_highest)
    else $error("lowest reading above highest reading");

  // A loaded result is always presented
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("result dropped");
`endif

endmodule

FILE: tb/hwtc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hwtc_checker
// Watches the sample, result and threshold channels of the tick counter.
// ----------------------------------------------------------------------------
// Keeps its own copy of the thresholds and of each channel's count, level
// flag and reading extremes. For every accepted item it works out the
// readout the block must return and queues it. Every accepted result is
// compared field by field with the oldest queued readout.
module hwtc_checker (
  input  logic   clk,
  input  logic   rst,
  hwtc_sample_if samples,
  hwtc_result_if results,
  hwtc_cfg_if    cfg,
  output int     mismatches,
  output int     outstanding
);

  import hwtc_pkg::*;

  typedef struct packed {
    logic [15:0]            tick_count;
    logic                   level;
    logic [SAMPLE_BITS-1:0] lowest_seen;
    logic [SAMPLE_BITS-1:0] highest_seen;
  } readout_t;

  logic [15:0]            tick_model  [2];
  logic                   level_model [2];
  logic [SAMPLE_BITS-1:0] low_model   [2];
  logic [SAMPLE_BITS-1:0] high_model  [2];
  logic [SAMPLE_BITS-1:0] low_thr;
  logic [SAMPLE_BITS-1:0] high_thr;
  readout_t               expected_readouts [$];
  int                     miss_count = 0;

  // Apply one item to the channel copy and return the channel afterwards
  function automatic readout_t count_reading(input op_t op, input logic ch,
                                             input logic [SAMPLE_BITS-1:0] reading,
                                             input logic [15:0] preset);
    readout_t r;
    if (op == OP_PRESET) begin
      tick_model[ch] = preset;
    end else begin
      // falling test first: with inverted thresholds one reading ticks twice
      if (reading < low_thr && level_model[ch]) begin
        tick_model[ch]  = tick_model[ch] + 16'd1;
        level_model[ch] = 1'b0;
      end
      if (reading > high_thr && !level_model[ch]) begin
        tick_model[ch]  = tick_model[ch] + 16'd1;
        level_model[ch] = 1'b1;
      end
      if (reading < low_model[ch]) low_model[ch] = reading;
      if (reading > high_model[ch]) high_model[ch] = reading;
    end
    r.tick_count   = tick_model[ch];
    r.level        = level_model[ch];
    r.lowest_seen  = low_model[ch];
    r.highest_seen = high_model[ch];
    return r;
  endfunction

  // Track threshold writes, check results, predict accepted items
  always @(posedge clk) begin
    readout_t want;
    readout_t got;
    if (rst) begin
      low_thr  = LOW_THRESHOLD_RESET;
      high_thr = HIGH_THRESHOLD_RESET;
      for (int c = 0; c < 2; c++) begin
        tick_model[c]  = '0;
        level_model[c] = 1'b0;
        low_model[c]   = MIN_READING_RESET;
        high_model[c]  = MAX_READING_RESET;
      end
      expected_readouts.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_index_t'(cfg.index))
          CFG_LOW_THRESHOLD:  low_thr  = cfg.data;
          CFG_HIGH_THRESHOLD: high_thr = cfg.data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        got.tick_count   = results.tick_count;
        got.level        = results.level;
        got.lowest_seen  = results.lowest_seen;
        got.highest_seen = results.highest_seen;
        if (expected_readouts.size() == 0) begin
          miss_count++;
          if (miss_count <= 10)
            $display("%0t: unexpected result count=%h level=%b low=%0d high=%0d",
                     $realtime, got.tick_count, got.level, got.lowest_seen,
                     got.highest_seen);
        end else begin
          want = expected_readouts.pop_front();
          if (got.tick_count !== want.tick_count || got.level !== want.level ||
              got.lowest_seen !== want.lowest_seen ||
              got.highest_seen !== want.highest_seen) begin
            miss_count++;
            if (miss_count <= 10) begin
              $display("%0t: result mismatch: expected count=%h level=%b low=%0d high=%0d",
                       $realtime, want.tick_count, want.level, want.lowest_seen,
                       want.highest_seen);
              $display("%0t: result mismatch: got      count=%h level=%b low=%0d high=%0d",
                       $realtime, got.tick_count, got.level, got.lowest_seen,
                       got.highest_seen);
            end
          end
        end
      end
      if (samples.valid && samples.ready)
        expected_readouts.push_back(count_reading(op_t'(samples.operation),
                                                  samples.channel, samples.sample,
                                                  samples.preset_value));
    end
    mismatches  <= miss_count;
    outstanding <= expected_readouts.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the hysteresis wheel tick counter.
// ----------------------------------------------------------------------------
// Runs a directed opening at the reset thresholds, then random samples and
// presets under several threshold pairs: the 8-bit pair, the widest and the
// inverted extremes, equal thresholds and a random pair. Both the item source
// and the result sink pause in random bursts, except in the closing stretch.
// The checker beside the block predicts and compares every result.
module testbench;

  import hwtc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic calm = 1'b0;
  logic sample_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   mismatches;
  int   outstanding;
  int   low_thr = 400;
  int   high_thr = 450;

  hwtc_sample_if sample_ch ();
  hwtc_result_if result_ch ();
  hwtc_cfg_if    cfg_ch ();

  hysteresis_wheel_tick_counter dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  hwtc_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .samples     (sample_ch),
    .results     (result_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  // Record handshakes at the edge, read them back at the next falling edge
  always @(posedge clk) begin
    sample_taken <= sample_ch.valid && sample_ch.ready;
    cfg_taken    <= cfg_ch.valid && cfg_ch.ready;
  end

  // Hand one item to the block, maybe after an idle burst
  task automatic send_item(input op_t op, input logic ch,
                           input logic [SAMPLE_BITS-1:0] reading,
                           input logic [15:0] preset);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid        = 1'b1;
    sample_ch.operation    = op;
    sample_ch.channel      = ch;
    sample_ch.sample       = reading;
    sample_ch.preset_value = preset;
    do @(negedge clk); while (!sample_taken);
  endtask

  // Write one threshold register
  task automatic write_reg(input cfg_index_t idx, input int value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value[CFG_DATA_BITS-1:0];
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid = 1'b0;
  endtask

  // Drain the block, then load a new threshold pair
  task automatic set_thresholds(input int lo, input int hi);
    sample_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_LOW_THRESHOLD, lo);
    write_reg(CFG_HIGH_THRESHOLD, hi);
    low_thr  = lo;
    high_thr = hi;
  endtask

  // Favor readings that cross or sit on the current thresholds
  function automatic logic [SAMPLE_BITS-1:0] pick_reading();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1023);
      1: v = $urandom_range(0, low_thr);
      2: v = $urandom_range(high_thr, 1023);
      3: v = low_thr + int'($urandom_range(0, 4)) - 2;
      4: v = high_thr + int'($urandom_range(0, 4)) - 2;
      default: v = $urandom_range(0, 1) ? 1023 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Random samples with an occasional preset, some close to wrapping
  task automatic run_random(input int count);
    logic [15:0] preset;
    for (int i = 0; i < count; i++) begin
      preset = $urandom_range(0, 2) == 0 ? 16'hFFFF - 16'($urandom_range(0, 3))
                                         : 16'($urandom);
      if ($urandom_range(0, 9) == 0)
        send_item(OP_PRESET, 1'($urandom), 10'($urandom), preset);
      else
        send_item(OP_SAMPLE, 1'($urandom), pick_reading(), preset);
    end
  endtask

  // Result sink: stall in random bursts, steady once calm
  initial begin
    int span;
    result_ch.ready = 1'b1;
    @(negedge clk);
    forever begin
      span = $urandom_range(1, 13);
      if (calm) begin
        result_ch.ready = 1'b1;
        @(negedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        result_ch.ready = 1'b0;
        repeat (span) @(negedge clk);
      end else begin
        result_ch.ready = 1'b1;
        repeat (span * $urandom_range(1, 3)) @(negedge clk);
      end
    end
  end

  // Main sequence
  initial begin
    sample_ch.valid        = 1'b0;
    sample_ch.operation    = OP_SAMPLE;
    sample_ch.channel      = 1'b0;
    sample_ch.sample       = '0;
    sample_ch.preset_value = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = CFG_LOW_THRESHOLD;
    cfg_ch.data            = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: untouched channel, wrap, equal readings, both crossings
    send_item(OP_PRESET, 1'b1, 10'd0,   16'h0000);
    send_item(OP_PRESET, 1'b0, 10'd0,   16'hFFFF);
    send_item(OP_SAMPLE, 1'b0, 10'd1023, 16'h0000);
    send_item(OP_SAMPLE, 1'b0, 10'd450, 16'h0000);
    send_item(OP_SAMPLE, 1'b0, 10'd400, 16'h0000);
    send_item(OP_SAMPLE, 1'b0, 10'd0,   16'h0000);
    send_item(OP_SAMPLE, 1'b1, 10'd451, 16'h0000);
    send_item(OP_SAMPLE, 1'b1, 10'd449, 16'h0000);
    send_item(OP_SAMPLE, 1'b1, 10'd399, 16'h0000);
    send_item(OP_PRESET, 1'b1, 10'h3FF, 16'hAAAA);
    send_item(OP_PRESET, 1'b0, 10'h3FF, 16'h5555);
    send_item(OP_SAMPLE, 1'b1, 10'h2AA, 16'hFFFF);
    send_item(OP_SAMPLE, 1'b1, 10'h155, 16'hFFFF);
    run_random(200);

    // 8-bit reading thresholds
    set_thresholds(70, 110);
    run_random(200);

    // Widest pair: the flag can never move
    set_thresholds(0, 1023);
    run_random(150);

    // Inverted pair: one reading falls and rises again
    set_thresholds(1023, 0);
    send_item(OP_SAMPLE, 1'b0, 10'd512, 16'h0000);
    send_item(OP_SAMPLE, 1'b0, 10'd512, 16'h0000);
    send_item(OP_PRESET, 1'b0, 10'd0,   16'hFFFE);
    run_random(150);

    set_thresholds(500, 500);
    run_random(150);

    set_thresholds($urandom_range(0, 1023), $urandom_range(0, 1023));
    run_random(200);

    // Closing stretch at the reset pair with no idling
    set_thresholds(400, 450);
    calm = 1'b1;
    run_random(150);

    sample_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
sv/hwtc_pkg.sv
sv/hwtc_sample_if.sv
sv/hwtc_result_if.sv
sv/hwtc_cfg_if.sv
sv/hysteresis_wheel_tick_counter.sv
tb/hwtc_checker.sv
tb/testbench.sv
